// ----- rtl/ray_triangle_edge_hit_2d_macros.svh -----
// assertion macros for the ray triangle edge hit block
// used by the top level; no other dependencies
`ifndef RAY_TRIANGLE_EDGE_HIT_2D_MACROS_SVH
`define RAY_TRIANGLE_EDGE_HIT_2D_MACROS_SVH

// same-cycle implication, masked while reset is high
`define RTEH_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rteh check failed: name");

// next-cycle implication, not masked by reset
`define RTEH_ASSERT_NEXT(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rteh check failed: name");

`endif

// ----- rtl/rteh_pkg.sv -----
// shared constants and types for the ray triangle edge hit block
// no dependencies
package rteh_pkg;

   // pipeline depth and stage positions
   localparam int NUM_STAGES = 6;
   localparam int ST_DIFF    = 0;
   localparam int ST_MUL     = 1;
   localparam int ST_CROSS   = 2;
   localparam int ST_NORM    = 3;
   localparam int ST_TEST    = 4;
   localparam int ST_OUT     = 5;

   // one lane per triangle edge
   localparam int NUM_EDGES  = 3;

   // per-stage advance strobes shared by lanes and merge
   typedef struct packed {
      logic [NUM_STAGES-1:0] adv;
   } pipe_ctrl_type;

endpackage

// ----- rtl/ray_triangle_edge_hit_2d.sv -----
// an accepted item passes the diff, mul, cross, norm, test and out stage registers to rsp_valid
// throughput: one item per cycle while rsp_stall is low, set by the six-stage pipeline
// any stage holding a bubble still takes an item while the output is stalled
// reset: synchronous, active high; clears all stage valid bits, no results pending
// top level of the ray triangle edge hit block
// depends on rteh_pkg, rteh_lane, rteh_merge and the macros header
`include "ray_triangle_edge_hit_2d_macros.svh"

module ray_triangle_edge_hit_2d
   import rteh_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_ray_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_ray_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_ray_through_x,
   input  logic signed [COORD_WIDTH-1:0] req_ray_through_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex0_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex0_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex1_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex1_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex2_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex2_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [2:0]                    rsp_edge_hits
);

   localparam int DW = COORD_WIDTH + 1;

   logic [NUM_STAGES:0]     ready;
   logic [NUM_STAGES-1:0]   valid_in, valid_ff, valid_src;
   pipe_ctrl_type           ctrl;
   logic signed [DW-1:0]    dir_x_in, dir_y_in, dir_x_ff, dir_y_ff;
   logic [ST_TEST:ST_DIFF]  ray_ok_ff;
   logic                    ray_ok_in;
   logic [NUM_EDGES-1:0]    lane_hits;
   logic signed [COORD_WIDTH-1:0] vert_x [NUM_EDGES];
   logic signed [COORD_WIDTH-1:0] vert_y [NUM_EDGES];

   // stage ready chain: a stage moves when empty or when the next one moves
   always_comb begin
      ready[NUM_STAGES] = !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign ctrl.adv  = ready[NUM_STAGES-1:0];
   assign valid_src = {valid_ff[NUM_STAGES-2:0], req_valid};
   assign valid_in  = (ctrl.adv & valid_src) | (~ctrl.adv & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ready[ST_DIFF];
   assign rsp_valid = valid_ff[ST_OUT];

   // ray direction, shared by all lanes
   assign dir_x_in  = DW'(req_ray_through_x) - DW'(req_ray_origin_x);
   assign dir_y_in  = DW'(req_ray_through_y) - DW'(req_ray_origin_y);
   assign ray_ok_in = (dir_x_in != '0) || (dir_y_in != '0);

   always_ff @(posedge clock) begin
      if (ctrl.adv[ST_DIFF]) begin
         dir_x_ff <= dir_x_in;
         dir_y_ff <= dir_y_in;
      end
   end

   // degenerate-ray flag rides along with the lanes
   always_ff @(posedge clock) begin
      if (ctrl.adv[ST_DIFF]) begin
         ray_ok_ff[ST_DIFF] <= ray_ok_in;
      end
      for (int k = ST_DIFF + 1; k <= ST_TEST; k++) begin
         if (ctrl.adv[k]) begin
            ray_ok_ff[k] <= ray_ok_ff[k-1];
         end
      end
   end

   // vertices in lane order
   assign vert_x[0] = req_vertex0_x;
   assign vert_y[0] = req_vertex0_y;
   assign vert_x[1] = req_vertex1_x;
   assign vert_y[1] = req_vertex1_y;
   assign vert_x[2] = req_vertex2_x;
   assign vert_y[2] = req_vertex2_y;

   // one lane per edge, edge i runs from vertex i to the next vertex
   for (genvar i = 0; i < NUM_EDGES; i++) begin : g_lane
      localparam int NEXT = (i + 1) % NUM_EDGES;
      rteh_lane #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_lane (
         .clock    (clock),
         .ctrl     (ctrl),
         .origin_x (req_ray_origin_x),
         .origin_y (req_ray_origin_y),
         .a_x      (vert_x[i]),
         .a_y      (vert_y[i]),
         .b_x      (vert_x[NEXT]),
         .b_y      (vert_y[NEXT]),
         .dir_x    (dir_x_ff),
         .dir_y    (dir_y_ff),
         .edge_hit (lane_hits[i])
      );
   end

   // merge lanes into the output item
   rteh_merge u_merge (
      .clock     (clock),
      .ctrl      (ctrl),
      .ray_ok    (ray_ok_ff[ST_TEST]),
      .lane_hits (lane_hits),
      .hit       (rsp_hit),
      .edge_hits (rsp_edge_hits)
   );

   // checks
   `RTEH_ASSERT_IMP(a_hit_is_or, clock, reset, rsp_valid, rsp_hit == (|rsp_edge_hits))
   `RTEH_ASSERT_IMP(a_no_stall_through, clock, reset, !rsp_stall, !req_stall)
   `RTEH_ASSERT_IMP(a_full_stalls, clock, reset, (&valid_ff) && rsp_stall, req_stall)
   `RTEH_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)

endmodule

// ----- rtl/rteh_lane.sv -----
// one edge lane: differences, cross products and range tests for one edge
// depends on rteh_pkg
module rteh_lane
   import rteh_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  pipe_ctrl_type                 ctrl,
   input  logic signed [COORD_WIDTH-1:0] origin_x,
   input  logic signed [COORD_WIDTH-1:0] origin_y,
   input  logic signed [COORD_WIDTH-1:0] a_x,
   input  logic signed [COORD_WIDTH-1:0] a_y,
   input  logic signed [COORD_WIDTH-1:0] b_x,
   input  logic signed [COORD_WIDTH-1:0] b_y,
   input  logic signed [COORD_WIDTH:0]   dir_x,
   input  logic signed [COORD_WIDTH:0]   dir_y,
   output logic                          edge_hit
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int CW = PW + 1;

   logic signed [DW-1:0] ex_in, ey_in, wx_in, wy_in;
   logic signed [DW-1:0] ex_ff, ey_ff, wx_ff, wy_ff;
   logic signed [PW-1:0] p_dxey_ff, p_dyex_ff, p_wxey_ff, p_wyex_ff, p_wxdy_ff, p_wydx_ff;
   logic signed [CW-1:0] den_in, tn_in, sn_in;
   logic signed [CW-1:0] den_ff, tn_ff, sn_ff;
   logic signed [CW-1:0] den_abs_in, tn_n_in, sn_n_in;
   logic signed [CW-1:0] den_abs_ff, tn_n_ff, sn_n_ff;
   logic                 nz_in, nz_ff;
   logic                 hit_in, hit_ff;

   // edge vector and origin-to-start vector
   assign ex_in = DW'(b_x) - DW'(a_x);
   assign ey_in = DW'(b_y) - DW'(a_y);
   assign wx_in = DW'(a_x) - DW'(origin_x);
   assign wy_in = DW'(a_y) - DW'(origin_y);

   always_ff @(posedge clock) begin
      if (ctrl.adv[ST_DIFF]) begin
         ex_ff <= ex_in;
         ey_ff <= ey_in;
         wx_ff <= wx_in;
         wy_ff <= wy_in;
      end
   end

   // six independent products, one multiplier deep
   always_ff @(posedge clock) begin
      if (ctrl.adv[ST_MUL]) begin
         p_dxey_ff <= PW'(dir_x) * PW'(ey_ff);
         p_dyex_ff <= PW'(dir_y) * PW'(ex_ff);
         p_wxey_ff <= PW'(wx_ff) * PW'(ey_ff);
         p_wyex_ff <= PW'(wy_ff) * PW'(ex_ff);
         p_wxdy_ff <= PW'(wx_ff) * PW'(dir_y);
         p_wydx_ff <= PW'(wy_ff) * PW'(dir_x);
      end
   end

   // cross products
   assign den_in = CW'(p_dxey_ff) - CW'(p_dyex_ff);
   assign tn_in  = CW'(p_wxey_ff) - CW'(p_wyex_ff);
   assign sn_in  = CW'(p_wxdy_ff) - CW'(p_wydx_ff);

   always_ff @(posedge clock) begin
      if (ctrl.adv[ST_CROSS]) begin
         den_ff <= den_in;
         tn_ff  <= tn_in;
         sn_ff  <= sn_in;
      end
   end

   // fold the sign of the denominator into the numerators
   always_comb begin
      nz_in = (den_ff != '0);
      if (den_ff[CW-1]) begin
         den_abs_in = -den_ff;
         tn_n_in    = -tn_ff;
         sn_n_in    = -sn_ff;
      end else begin
         den_abs_in = den_ff;
         tn_n_in    = tn_ff;
         sn_n_in    = sn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[ST_NORM]) begin
         nz_ff      <= nz_in;
         den_abs_ff <= den_abs_in;
         tn_n_ff    <= tn_n_in;
         sn_n_ff    <= sn_n_in;
      end
   end

   // ray parameter non-negative, edge parameter within [0, 1]
   assign hit_in = nz_ff && !tn_n_ff[CW-1] && !sn_n_ff[CW-1] && (sn_n_ff <= den_abs_ff);

   always_ff @(posedge clock) begin
      if (ctrl.adv[ST_TEST]) begin
         hit_ff <= hit_in;
      end
   end

   assign edge_hit = hit_ff;

endmodule

// ----- rtl/rteh_merge.sv -----
// merge stage: combines the lane results into the output item registers
// depends on rteh_pkg
module rteh_merge
   import rteh_pkg::*;
(
   input  logic                 clock,
   input  pipe_ctrl_type        ctrl,
   input  logic                 ray_ok,
   input  logic [NUM_EDGES-1:0] lane_hits,
   output logic                 hit,
   output logic [NUM_EDGES-1:0] edge_hits
);

   logic [NUM_EDGES-1:0] edge_hits_in, edge_hits_ff;
   logic                 hit_in, hit_ff;

   // a degenerate ray clears every edge
   assign edge_hits_in = ray_ok ? lane_hits : '0;
   assign hit_in       = |edge_hits_in;

   always_ff @(posedge clock) begin
      if (ctrl.adv[ST_OUT]) begin
         edge_hits_ff <= edge_hits_in;
         hit_ff       <= hit_in;
      end
   end

   assign hit       = hit_ff;
   assign edge_hits = edge_hits_ff;

endmodule

// ----- verif/ray_triangle_edge_hit_2d_tb.sv -----
// self-checking testbench for the ray triangle edge hit block
// depends on ray_triangle_edge_hit_2d; drives a directed table then random items
module ray_triangle_edge_hit_2d_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW              = 16;
   localparam int RANDOM_ITEMS    = 1700;
   localparam int NO_TYPED        = -1;
   localparam int PRESSURE_AT     = 500;
   localparam int PRESSURE_SPAN   = 150;
   localparam int PRESSURE_CYCLES = 120;
   localparam int DRAIN_CYCLES    = 16;
   localparam int CYCLE_LIMIT     = 500000;

   // one item: ray origin, ray through point, three vertices
   typedef struct packed {
      logic [CW-1:0] ox, oy, px, py;
      logic [CW-1:0] ax, ay, bx, by, cx, cy;
   } ray_tri_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] edge_hits;
   } hit_result_type;

   typedef struct packed {
      ray_tri_type    geo;
      logic           typed;
      hit_result_type want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [CW-1:0] req_ray_origin_x, req_ray_origin_y;
   logic signed [CW-1:0] req_ray_through_x, req_ray_through_y;
   logic signed [CW-1:0] req_vertex0_x, req_vertex0_y;
   logic signed [CW-1:0] req_vertex1_x, req_vertex1_y;
   logic signed [CW-1:0] req_vertex2_x, req_vertex2_y;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_hit;
   logic [2:0] rsp_edge_hits;

   hit_result_type hits_due [$];
   hit_result_type pending_want;
   table_row_type  directed_rows [$];
   int          mismatch_count = 0;
   int          items_taken = 0;
   int          results_seen = 0;
   int          cycle_count = 0;
   bit          tx_quiet = 1'b0;
   bit          rx_quiet = 1'b0;

   ray_triangle_edge_hit_2d #(.COORD_WIDTH(CW)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ray_origin_x  (req_ray_origin_x),
      .req_ray_origin_y  (req_ray_origin_y),
      .req_ray_through_x (req_ray_through_x),
      .req_ray_through_y (req_ray_through_y),
      .req_vertex0_x     (req_vertex0_x),
      .req_vertex0_y     (req_vertex0_y),
      .req_vertex1_x     (req_vertex1_x),
      .req_vertex1_y     (req_vertex1_y),
      .req_vertex2_x     (req_vertex2_x),
      .req_vertex2_y     (req_vertex2_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_edge_hits     (rsp_edge_hits)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // does the ray from o along d meet the closed segment a-b
   function automatic bit segment_crossed(input longint ox, input longint oy,
                                          input longint dx, input longint dy,
                                          input longint ax, input longint ay,
                                          input longint bx, input longint by);
      longint ex, ey, wx, wy, den, tn, sn;
      ex  = bx - ax;
      ey  = by - ay;
      wx  = ax - ox;
      wy  = ay - oy;
      den = dx * ey - dy * ex;
      tn  = wx * ey - wy * ex;
      sn  = wx * dy - wy * dx;
      if (den == 0)
         return 1'b0;
      if (den < 0) begin
         den = -den;
         tn  = -tn;
         sn  = -sn;
      end
      return (tn >= 0) && (sn >= 0) && (sn <= den);
   endfunction

   // per-edge hit mask for one item, exact integer math
   function automatic hit_result_type predict_edge_hits(input ray_tri_type g);
      hit_result_type r;
      longint ox, oy, dx, dy, x0, y0, x1, y1, x2, y2;
      ox = $signed(g.ox);
      oy = $signed(g.oy);
      dx = longint'($signed(g.px)) - ox;
      dy = longint'($signed(g.py)) - oy;
      x0 = $signed(g.ax);
      y0 = $signed(g.ay);
      x1 = $signed(g.bx);
      y1 = $signed(g.by);
      x2 = $signed(g.cx);
      y2 = $signed(g.cy);
      r.edge_hits = 3'b000;
      // degenerate ray hits nothing
      if (dx != 0 || dy != 0) begin
         r.edge_hits[0] = segment_crossed(ox, oy, dx, dy, x0, y0, x1, y1);
         r.edge_hits[1] = segment_crossed(ox, oy, dx, dy, x1, y1, x2, y2);
         r.edge_hits[2] = segment_crossed(ox, oy, dx, dy, x2, y2, x0, y0);
      end
      r.hit = |r.edge_hits;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("mismatch on result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
      mismatch_count++;
   endtask

   // mostly short gaps, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic int full_coord();
      return $urandom_range(0, 65535) - 32768;
   endfunction

   function automatic int corner_coord();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return full_coord();
      endcase
   endfunction

   function automatic ray_tri_type pack_geometry(input int c [10]);
      ray_tri_type g;
      g.ox = c[0][CW-1:0];
      g.oy = c[1][CW-1:0];
      g.px = c[2][CW-1:0];
      g.py = c[3][CW-1:0];
      g.ax = c[4][CW-1:0];
      g.ay = c[5][CW-1:0];
      g.bx = c[6][CW-1:0];
      g.by = c[7][CW-1:0];
      g.cx = c[8][CW-1:0];
      g.cy = c[9][CW-1:0];
      return g;
   endfunction

   // random item, biased toward rays that reach the triangle
   function automatic ray_tri_type random_geometry();
      int c [10];
      int kind, k, lim, i, m, dx, dy;
      kind = $urandom_range(0, 99);
      lim  = 1 << $urandom_range(2, 7);
      for (i = 0; i < 10; i++)
         c[i] = $urandom_range(0, 2 * lim) - lim;
      if (kind < 35) begin
         // small window: dense hits, touching and parallel cases
      end else if (kind < 60) begin
         // ray aimed at a vertex or at an edge midpoint
         for (i = 0; i < 10; i++)
            c[i] = full_coord();
         k = $urandom_range(0, 5);
         if (k < 3) begin
            c[2] = c[4 + 2 * k];
            c[3] = c[5 + 2 * k];
         end else begin
            m    = (k - 3 + 1) % 3;
            c[2] = (c[4 + 2 * (k - 3)] + c[4 + 2 * m]) / 2;
            c[3] = (c[5 + 2 * (k - 3)] + c[5 + 2 * m]) / 2;
         end
         // sometimes start on a vertex
         if ($urandom_range(0, 3) == 0) begin
            k    = $urandom_range(0, 2);
            c[0] = c[4 + 2 * k];
            c[1] = c[5 + 2 * k];
         end
      end else if (kind < 70) begin
         // field extremes
         for (i = 0; i < 10; i++)
            c[i] = corner_coord();
      end else if (kind < 82) begin
         // degenerate ray, degenerate edge, collinear or parallel edges
         dx = c[2] - c[0];
         dy = c[3] - c[1];
         case ($urandom_range(0, 3))
            0: begin
               c[2] = c[0];
               c[3] = c[1];
            end
            1: begin
               k = $urandom_range(0, 2);
               m = (k + 1) % 3;
               c[4 + 2 * m] = c[4 + 2 * k];
               c[5 + 2 * m] = c[5 + 2 * k];
            end
            2: begin
               for (i = 0; i < 3; i++) begin
                  m = $urandom_range(0, 6) - 3;
                  c[4 + 2 * i] = c[0] + m * dx;
                  c[5 + 2 * i] = c[1] + m * dy;
               end
            end
            default: begin
               m    = $urandom_range(0, 6) - 3;
               c[6] = c[4] + m * dx;
               c[7] = c[5] + m * dy;
            end
         endcase
      end else begin
         for (i = 0; i < 10; i++)
            c[i] = full_coord();
      end
      return pack_geometry(c);
   endfunction

   task automatic add_row(input int ox, input int oy, input int px, input int py,
                          input int ax, input int ay, input int bx, input int by,
                          input int cx, input int cy, input int typed_mask);
      table_row_type row;
      int c [10];
      c = '{ox, oy, px, py, ax, ay, bx, by, cx, cy};
      row.geo   = pack_geometry(c);
      row.typed = (typed_mask != NO_TYPED);
      row.want.edge_hits = typed_mask[2:0];
      row.want.hit       = |typed_mask[2:0];
      directed_rows.push_back(row);
   endtask

   // directed items; the typed rows are the plain miss cases
   task automatic build_directed_table();
      // degenerate rays, including at the field extremes
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(32767, 32767, 32767, 32767, -32768, -32768, 32767, -32768,
              -32768, 32767, 0);
      add_row(-32768, -32768, -32768, -32768, 32767, 32767, -32768, 32767,
              32767, -32768, 0);
      // triangle shrunk to one point
      add_row(0, 0, 1, 1, 5, 5, 5, 5, 5, 5, 0);
      // triangle flat on the ray's line
      add_row(0, 0, 1, 0, -5, 0, 3, 0, 10, 0, 0);
      // ray pointing away
      add_row(100, 0, 101, 0, -10, -10, 10, -10, 0, 10, 0);
      // origin inside
      add_row(0, 0, 1, 0, -10, -10, 10, -10, 0, 10, NO_TYPED);
      // through the interior and out at a vertex
      add_row(0, -20, 0, -19, -10, -10, 10, -10, 0, 10, NO_TYPED);
      // origin on an edge
      add_row(0, -10, 0, -11, -10, -10, 10, -10, 0, 10, NO_TYPED);
      // grazing a vertex from outside
      add_row(-20, 10, -19, 10, -10, -10, 10, -10, 0, 10, NO_TYPED);
      // parallel to one edge
      add_row(0, -20, 1, -20, -10, -10, 10, -10, 0, 10, NO_TYPED);
      add_row(0, -10, 1, -10, -10, -10, 10, -10, 0, 10, NO_TYPED);
      // full range diagonals and corners
      add_row(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
              32767, 32767, NO_TYPED);
      add_row(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767,
              0, 32767, NO_TYPED);
      add_row(0, 0, -32768, -32768, 32767, 32767, -32768, 32767,
              -32768, -32768, NO_TYPED);
      add_row(-32768, 32767, -32768, -32768, -32768, 0, 32767, 0,
              0, -32768, NO_TYPED);
      add_row(-1, -1, 32767, -32768, 100, -200, 200, -100, 300, -400, NO_TYPED);
      add_row(-32768, 0, 32767, 1, 0, -1, 0, 1, 1, 0, NO_TYPED);
      add_row(3, 50, 3, 49, -10, -10, 10, -10, 0, 10, NO_TYPED);
      // one edge with both ends equal
      add_row(0, 0, 1, 0, 5, -5, 5, -5, 5, 5, NO_TYPED);
   endtask

   task automatic send_item(input ray_tri_type g, input hit_result_type want);
      @(negedge clock);
      req_valid         <= 1'b1;
      req_ray_origin_x  <= g.ox;
      req_ray_origin_y  <= g.oy;
      req_ray_through_x <= g.px;
      req_ray_through_y <= g.py;
      req_vertex0_x     <= g.ax;
      req_vertex0_y     <= g.ay;
      req_vertex1_x     <= g.bx;
      req_vertex1_y     <= g.by;
      req_vertex2_x     <= g.cx;
      req_vertex2_y     <= g.cy;
      pending_want      <= want;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic idle_sender();
      int n;
      if (tx_quiet || (items_taken >= PRESSURE_AT &&
                       items_taken < PRESSURE_AT + PRESSURE_SPAN))
         n = 0;
      else
         n = pick_gap();
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      if ($urandom_range(0, 63) == 0)
         tx_quiet = !tx_quiet;
   endtask

   // sender: directed table, then random items, then drain
   initial begin : stimulus
      ray_tri_type    g;
      hit_result_type want;
      int             n;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_ray_origin_x  = '0;
      req_ray_origin_y  = '0;
      req_ray_through_x = '0;
      req_ray_through_y = '0;
      req_vertex0_x     = '0;
      req_vertex0_y     = '0;
      req_vertex1_x     = '0;
      req_vertex1_y     = '0;
      req_vertex2_x     = '0;
      req_vertex2_y     = '0;
      pending_want      = '0;
      build_directed_table();
      repeat (6)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         want = directed_rows[i].typed ? directed_rows[i].want
                                       : predict_edge_hits(directed_rows[i].geo);
         send_item(directed_rows[i].geo, want);
         idle_sender();
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         g = random_geometry();
         send_item(g, predict_edge_hits(g));
         idle_sender();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // wait for outstanding results, then let the pipe settle
      while (hits_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (mismatch_count == 0 && hits_due.size() == 0)
         $display("** ray_triangle_edge_hit_2d: PASSED **");
      else
         $display("** ray_triangle_edge_hit_2d: FAILED **");
      $finish;
   end

   // receiver: random stalls, quiet stretches, one long hold-off
   initial begin : receiver
      int  hold;
      bit  pressure_done;
      pressure_done = 1'b0;
      rsp_stall     = 1'b0;
      forever begin
         if (!pressure_done && items_taken >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold = PRESSURE_CYCLES;
         end else begin
            hold = rx_quiet ? 0 : pick_gap();
         end
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1)
               @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 63) == 0)
            rx_quiet = !rx_quiet;
      end
   end

   // record accepted items and check accepted results
   always @(posedge clock) begin : scoreboard
      hit_result_type due;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            hits_due.push_back(pending_want);
            items_taken <= items_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (hits_due.size() == 0) begin
               flag_mismatch("result with nothing outstanding, hit", rsp_hit, 0);
            end else begin
               due = hits_due.pop_front();
               if (rsp_hit !== due.hit)
                  flag_mismatch("hit", rsp_hit, due.hit);
               if (rsp_edge_hits !== due.edge_hits)
                  flag_mismatch("edge_hits", rsp_edge_hits, due.edge_hits);
            end
            results_seen <= results_seen + 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles", cycle_count);
         $display("** ray_triangle_edge_hit_2d: FAILED **");
         $finish;
      end
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rteh_pkg.sv
rtl/rteh_lane.sv
rtl/rteh_merge.sv
rtl/ray_triangle_edge_hit_2d.sv
verif/ray_triangle_edge_hit_2d_tb.sv
